// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the edge trigger finder.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clock edge, outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: property check failed");
// Check that a condition never holds on a rising clock edge, outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ===== rtl/setf_pkg.sv =====
// Shared constants of the scope edge trigger finder.
// No dependencies; imported by the top level.
package setf_pkg;

    localparam int DEF_BUFFER_DEPTH = 1024;
    localparam int DEF_SAMPLE_BITS  = 16;

    // Result index field and the stream word that carries it
    localparam int INDEX_W    = 10;
    localparam int OUT_DATA_W = ((INDEX_W + 7) / 8) * 8;

    // Register map
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_LEVEL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FALLING_EDGE  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AUTO_MODE     = 2'd3;

    // Reset tolerance, about 0.05 in Q1.15
    localparam int TOL_RESET = 1638;

endpackage

// ===== rtl/setf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the sample buffer of the trigger finder.
module setf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/scope_edge_trigger_finder.sv =====
// Top level of the scope edge trigger finder: load stage, trigger scaling and scan sequencer.
// Depends on setf_pkg, setf_ram and assert_macros.svh.
//
// Samples stream in one per cycle while the block loads a buffer; the running maximum is
// kept on the fly and samples past BUFFER_DEPTH are dropped. The request marked with tlast
// closes the buffer: the block then stops taking samples, forms the trigger in two steps
// (in auto mode a multiply of maximum by level, then an arithmetic shift; otherwise the
// level itself), scans the stored buffer through the single read port of the sample RAM
// at one sample per cycle, and stops at the first sample within tolerance of the trigger
// that is followed by an edge in the selected direction, then waits for the previous
// result to be taken. The result (tuser = found, tdata = index) sits in an output
// register, so loading of the next buffer starts while it waits to be taken.
// Configuration writes are taken at any time and should be made while the block is idle.
`include "assert_macros.svh"

module scope_edge_trigger_finder #(
    parameter int BUFFER_DEPTH = setf_pkg::DEF_BUFFER_DEPTH,
    parameter int SAMPLE_BITS  = setf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // sample stream in
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       i_s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                                   i_s_tlast,   // last sample of the buffer
    // result stream out
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [setf_pkg::OUT_DATA_W-1:0]        o_m_tdata,   // [INDEX_W-1:0] index
    output logic                                   o_m_tuser,   // found
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [setf_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [SAMPLE_BITS-1:0]                 i_cfg_wdata
);

    import setf_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = 2 * SB;
    localparam int DW = SB + 2;

    localparam logic [CW-1:0] DEPTH_C  = CW'(BUFFER_DEPTH);
    localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_TRIG = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // control state
    logic [2:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_raddr, n_raddr;
    logic                    r_dv, n_dv;
    logic                    r_ovld, n_ovld;
    logic signed [SB-1:0]    r_max, n_max;
    // configuration
    logic signed [SB-1:0]    r_level;
    logic [SB-2:0]           r_tol;
    logic                    r_fall;
    logic                    r_auto;
    // payload
    logic signed [PW-1:0]    r_prod, n_prod;
    logic signed [SB:0]      r_trig, n_trig;
    logic [AW-1:0]           r_didx, n_didx;
    logic signed [SB-1:0]    r_prev, n_prev;
    logic                    r_found, n_found;
    logic [AW-1:0]           r_hidx, n_hidx;
    logic                    r_ofound, n_ofound;
    logic [INDEX_W-1:0]      r_oidx, n_oidx;

    logic                    s_accept;
    logic                    s_store;
    logic signed [SB-1:0]    s_sample;
    logic signed [SB-1:0]    ram_rdata;
    logic                    issue;
    logic signed [PW-1:0]    prod_sh;
    logic signed [DW-1:0]    diff;
    logic [DW-1:0]           diff_abs;
    logic                    in_window;
    logic                    edge_ok;
    logic                    hit;
    logic                    last_data;
    logic                    out_free;

    assign s_sample   = i_s_tdata[SB-1:0];
    assign o_s_tready = (r_state == ST_LOAD);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_store    = s_accept && (r_count < DEPTH_C);
    assign issue      = (r_state == ST_SCAN) && (r_raddr < r_count);

    setf_ram #(
        .WIDTH (SB),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s_store),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (s_sample),
        .i_raddr (r_raddr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Compare unit: distance to trigger and edge direction for the pair in flight, plus trigger shift and flags
    always_comb begin
        diff      = DW'(r_prev) - DW'(r_trig);
        diff_abs  = diff[DW-1] ? DW'(-diff) : DW'(diff);
        in_window = diff_abs < DW'(r_tol);
        edge_ok   = r_fall ? (ram_rdata < r_prev) : (ram_rdata > r_prev);
        hit       = r_dv && (r_didx != '0) && in_window && edge_ok;
        last_data = r_dv && (CW'(r_didx) == (r_count - CW'(1)));
        prod_sh   = r_prod >>> (SB - 1);
        out_free  = !r_ovld || i_m_tready;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_max    = r_max;
        n_raddr  = r_raddr;
        n_dv     = 1'b0;
        n_ovld   = r_ovld;
        n_prod   = r_prod;
        n_trig   = r_trig;
        n_didx   = r_didx;
        n_prev   = r_prev;
        n_found  = r_found;
        n_hidx   = r_hidx;
        n_ofound = r_ofound;
        n_oidx   = r_oidx;

        if (r_ovld && i_m_tready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            ST_LOAD: begin
                if (s_store) begin
                    n_count = r_count + CW'(1);
                    if (s_sample > r_max) begin
                        n_max = s_sample;
                    end
                end
                if (s_accept && i_s_tlast) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = r_max * r_level;
                n_state = ST_TRIG;
            end
            ST_TRIG: begin
                n_trig  = r_auto ? prod_sh[SB:0] : {r_level[SB-1], r_level};
                n_raddr = '0;
                n_found = 1'b0;
                n_hidx  = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // advance the read pointer; the data comes back in the next cycle
                if (issue) begin
                    n_raddr = r_raddr + CW'(1);
                    n_dv    = 1'b1;
                    n_didx  = r_raddr[AW-1:0];
                end
                if (r_dv) begin
                    n_prev = ram_rdata;
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_hidx  = r_didx - AW'(1);
                    n_dv    = 1'b0;
                    n_state = ST_DONE;
                end else if (last_data || (!r_dv && !issue)) begin
                    n_dv    = 1'b0;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (out_free) begin
                    n_ovld   = 1'b1;
                    n_ofound = r_found;
                    n_oidx   = r_found ? INDEX_W'(r_hidx) : '0;
                    n_count  = '0;
                    n_max    = MOST_NEG;
                    n_state  = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_max   <= MOST_NEG;
            r_raddr <= '0;
            r_dv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_max   <= n_max;
            r_raddr <= n_raddr;
            r_dv    <= n_dv;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_trig   <= n_trig;
        r_didx   <= n_didx;
        r_prev   <= n_prev;
        r_found  <= n_found;
        r_hidx   <= n_hidx;
        r_ofound <= n_ofound;
        r_oidx   <= n_oidx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_tol   <= (SB-1)'(TOL_RESET);
            r_fall  <= 1'b0;
            r_auto  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_TRIGGER_LEVEL: r_level <= i_cfg_wdata;
                REG_TOLERANCE:     r_tol   <= i_cfg_wdata[SB-2:0];
                REG_FALLING_EDGE:  r_fall  <= i_cfg_wdata[0];
                REG_AUTO_MODE:     r_auto  <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = OUT_DATA_W'(r_oidx);
    assign o_m_tuser  = r_ofound;

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > DEPTH_C)
    `ASSERT_PROP(a_notfound_zero, i_clk, i_rst_n, (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
    `ASSERT_PROP(a_done_holds, i_clk, i_rst_n,
                 (r_state == ST_DONE && r_ovld && !i_m_tready) |=> (r_state == ST_DONE))
    `ASSERT_PROP(a_buffer_cleared, i_clk, i_rst_n,
                 (r_state == ST_DONE && out_free) |=> (r_count == '0 && r_max == MOST_NEG))
    `ASSERT_NEVER(a_no_load_in_scan, i_clk, i_rst_n, s_store && r_state == ST_SCAN)

endmodule
